// ===== hw/rtl/data_run_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// data_run_decoder_defines : assertion macros for the data run decoder
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DATA_RUN_DECODER_DEFINES_SVH
`define DATA_RUN_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("data_run_decoder: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("data_run_decoder: next-cycle check failed");

`endif

// ===== hw/rtl/drl_pkg.sv =====
// ----------------------------------------------------------------------------
// drl_pkg : shared definitions for the data run decoder
// Widths, phase and status codes, and the run request passed front to back.
// ----------------------------------------------------------------------------
package drl_pkg;

    localparam int MAX_FIELD_BYTES = 8;
    localparam int POSITION_BITS   = 12;
    localparam int WORD_W          = 64;
    localparam int LANES           = WORD_W / 8;
    localparam int LANE_W          = $clog2(LANES);
    localparam int SIZE_W          = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;

    localparam logic [POSITION_BITS-1:0] POS_MAX            = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] STREAM_LIMIT_RESET = {POSITION_BITS{1'b1}};
    localparam logic [SIZE_W-1:0]        MAX_SIZE           = SIZE_W'(MAX_FIELD_BYTES);

    // register index carried by paddr[2]
    localparam logic REG_STREAM_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_OFFSET  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_UNALLOC = 2'd1,
        ST_END     = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    // One request per emitted result. offset is already sign-extended;
    // restart asks the back end to clear the running cluster first.
    typedef struct packed {
        status_t             status;
        logic                restart;
        logic                first;
        logic [WORD_W-1:0]   length;
        logic [WORD_W-1:0]   offset;
    } run_cmd_t;

endpackage

// ===== hw/rtl/data_run_decoder.sv =====
// Path: a byte that closes a run (or ends the stream) enters the request queue
//   at its accepting edge, then the output register once it is free or taken.
// Throughput: one byte per cycle; a stalled output fills the two-entry queue,
//   after which in_stall holds the input until the back end pops again.
// Reset: asynchronous, active low; decoder stopped until a start request,
//   stream_limit returns to 4095, no clearing pass.
// ----------------------------------------------------------------------------
// data_run_decoder : mapping-pairs data run decoder
// Byte-serial front end classifies header and field bytes, back end tracks
// the running cluster; a short queue decouples the two.
// ----------------------------------------------------------------------------
`include "data_run_decoder_defines.svh"

module data_run_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [drl_pkg::ADDR_W-1:0]          paddr,
    input  logic [drl_pkg::DATA_W-1:0]          pwdata,
    output logic [drl_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // byte stream in
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic [7:0]                          data_byte,
    // run results out
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [drl_pkg::WORD_W-1:0]          run_length,
    output logic signed [drl_pkg::WORD_W-1:0]   cluster,
    output logic                                first_run
);

    logic [drl_pkg::POSITION_BITS-1:0]  stream_limit_reg, stream_limit_next;
    logic                               cfg_write;
    logic                               q_push, q_pop, q_valid, q_full;
    logic [drl_pkg::QCNT_W-1:0]         q_count;
    drl_pkg::run_cmd_t                  push_cmd, head_cmd;
    logic                               q_at_depth, out_closing, out_taken;

    // ---- configuration: single register, stream_limit at byte address 0 ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        stream_limit_next = stream_limit_reg;
        if (cfg_write && paddr[2] == drl_pkg::REG_STREAM_LIMIT)
            stream_limit_next = pwdata[drl_pkg::POSITION_BITS-1:0];
    end

    // read back the limit while paddr[2] is clear; other addresses read as zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == drl_pkg::REG_STREAM_LIMIT)
            prdata = drl_pkg::DATA_W'(stream_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stream_limit_reg <= drl_pkg::STREAM_LIMIT_RESET;
        else
            stream_limit_reg <= stream_limit_next;
    end

    // ---- front: accept bytes, assemble fields, raise one request per result ----
    drl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .data_byte    (data_byte),
        .stream_limit (stream_limit_reg),
        .q_full       (q_full),
        .push         (q_push),
        .cmd          (push_cmd)
    );

    // ---- queue: hold requests while the output side stalls ----
    drl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .head      (head_cmd),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .count     (q_count)
    );

    // ---- back: advance the running cluster and drive the result register ----
    drl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .q_valid    (q_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .run_length (run_length),
        .cluster    (cluster),
        .first_run  (first_run)
    );

    // ---- checks ----
    assign q_at_depth  = q_count == drl_pkg::QCNT_W'(drl_pkg::QUEUE_DEPTH);
    assign out_closing = out_valid
                         && (status == drl_pkg::ST_END || status == drl_pkg::ST_ERROR);
    assign out_taken   = out_valid && !out_stall;

    // the front must never raise a request that the queue cannot take
    `DRL_ASSERT_SAME(a_no_push_when_full, clk, rst_n, q_push, !q_at_depth)
    // end and error results carry no length and never mark a first run
    `DRL_ASSERT_SAME(a_end_fields, clk, rst_n, out_closing, run_length == '0 && !first_run)
    // a taken result with nothing queued behind it leaves the output empty
    `DRL_ASSERT_NEXT(a_drain, clk, rst_n, out_taken && !q_valid, !out_valid)

endmodule

// ===== hw/rtl/drl_front.sv =====
// ----------------------------------------------------------------------------
// drl_front : byte classifier and field assembler
// Tracks header/length/offset phase and builds one run request per run.
// ----------------------------------------------------------------------------
module drl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic [7:0]                          data_byte,
    input  logic [drl_pkg::POSITION_BITS-1:0]   stream_limit,
    input  logic                                q_full,
    output logic                                push,
    output drl_pkg::run_cmd_t                   cmd
);

    drl_pkg::phase_t                     phase_reg, phase_next, eff_phase;
    logic [drl_pkg::SIZE_W-1:0]          lsize_reg, lsize_next;
    logic [drl_pkg::SIZE_W-1:0]          osize_reg, osize_next;
    logic [drl_pkg::SIZE_W-1:0]          cnt_reg, cnt_next, cnt_inc;
    logic [drl_pkg::WORD_W-1:0]          len_reg, len_next, len_wr;
    logic [drl_pkg::WORD_W-1:0]          off_reg, off_next, off_wr;
    logic [drl_pkg::POSITION_BITS-1:0]   pos_reg, pos_next, eff_pos;
    logic                                first_reg, first_next, eff_first;
    logic                                restart_reg, restart_next, eff_restart;
    logic                                accept;
    logic [drl_pkg::SIZE_W-1:0]          hdr_len, hdr_off;
    logic                                hdr_end, hdr_bad, len_done, off_done;
    logic [drl_pkg::LANE_W-1:0]          lane;

    assign in_stall    = q_full;
    assign accept      = in_valid && !q_full;
    assign eff_phase   = start_req ? drl_pkg::PH_HEADER : phase_reg;
    assign eff_pos     = start_req ? '0 : pos_reg;
    assign eff_first   = start_req | first_reg;
    assign eff_restart = start_req | restart_reg;
    assign hdr_len     = data_byte[3:0];
    assign hdr_off     = data_byte[7:4];
    assign hdr_end     = (eff_pos > stream_limit) || (data_byte == 8'd0);
    assign hdr_bad     = (hdr_len > drl_pkg::MAX_SIZE) || (hdr_off > drl_pkg::MAX_SIZE);
    assign cnt_inc     = cnt_reg + 4'd1;
    assign len_done    = cnt_inc >= lsize_reg;
    assign off_done    = cnt_inc >= osize_reg;
    assign lane        = cnt_reg[drl_pkg::LANE_W-1:0];

    // byte lanes: length takes the byte in place, offset also fills sign above
    always_comb
    begin
        len_wr = len_reg;
        off_wr = off_reg;
        for (int i = 0; i < drl_pkg::LANES; i++)
        begin
            if (drl_pkg::LANE_W'(i) == lane)
            begin
                len_wr[i*8 +: 8] = data_byte;
                off_wr[i*8 +: 8] = data_byte;
            end
            else if (drl_pkg::LANE_W'(i) > lane)
            begin
                off_wr[i*8 +: 8] = {8{data_byte[7]}};
            end
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (eff_phase)
                drl_pkg::PH_HEADER:
                begin
                    if (hdr_end || hdr_bad)
                        phase_next = drl_pkg::PH_STOPPED;
                    else if (hdr_len != '0)
                        phase_next = drl_pkg::PH_LENGTH;
                    else
                        phase_next = drl_pkg::PH_OFFSET;
                end
                drl_pkg::PH_LENGTH:
                begin
                    if (len_done)
                        phase_next = (osize_reg == '0) ? drl_pkg::PH_HEADER
                                                       : drl_pkg::PH_OFFSET;
                end
                drl_pkg::PH_OFFSET:
                begin
                    if (off_done)
                        phase_next = drl_pkg::PH_HEADER;
                end
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // datapath and request outputs
    always_comb
    begin
        lsize_next   = lsize_reg;
        osize_next   = osize_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        off_next     = off_reg;
        pos_next     = pos_reg;
        first_next   = first_reg;
        restart_next = restart_reg;
        push         = 1'b0;
        cmd.status   = drl_pkg::ST_END;
        cmd.restart  = eff_restart;
        cmd.first    = 1'b0;
        cmd.length   = '0;
        cmd.offset   = '0;
        if (accept && eff_phase != drl_pkg::PH_STOPPED)
        begin
            first_next   = eff_first;
            restart_next = eff_restart;
            pos_next     = (eff_pos < drl_pkg::POS_MAX) ? eff_pos + 1'b1 : eff_pos;
            unique case (eff_phase)
                drl_pkg::PH_HEADER:
                begin
                    if (hdr_end || hdr_bad)
                    begin
                        push       = 1'b1;
                        cmd.status = hdr_end ? drl_pkg::ST_END : drl_pkg::ST_ERROR;
                    end
                    else
                    begin
                        lsize_next = hdr_len;
                        osize_next = hdr_off;
                        cnt_next   = '0;
                        len_next   = '0;
                        off_next   = '0;
                    end
                end
                drl_pkg::PH_LENGTH:
                begin
                    len_next = len_wr;
                    cnt_next = len_done ? '0 : cnt_inc;
                    if (len_done && osize_reg == '0)
                    begin
                        push       = 1'b1;
                        cmd.status = drl_pkg::ST_UNALLOC;
                        cmd.first  = eff_first;
                        cmd.length = len_wr;
                    end
                end
                drl_pkg::PH_OFFSET:
                begin
                    off_next = off_wr;
                    cnt_next = off_done ? '0 : cnt_inc;
                    if (off_done)
                    begin
                        push       = 1'b1;
                        cmd.status = drl_pkg::ST_ALLOC;
                        cmd.first  = eff_first;
                        cmd.length = len_reg;
                        cmd.offset = off_wr;
                    end
                end
                default:
                    push = 1'b0;
            endcase
            // a run closes the first-run window; any request carries the restart
            if (push)
            begin
                restart_next = 1'b0;
                if (cmd.status == drl_pkg::ST_ALLOC || cmd.status == drl_pkg::ST_UNALLOC)
                    first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= drl_pkg::PH_STOPPED;
            lsize_reg   <= '0;
            osize_reg   <= '0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            off_reg     <= '0;
            pos_reg     <= '0;
            first_reg   <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            lsize_reg   <= lsize_next;
            osize_reg   <= osize_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            off_reg     <= off_next;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            restart_reg <= restart_next;
        end
    end

endmodule

// ===== hw/rtl/drl_queue.sv =====
// ----------------------------------------------------------------------------
// drl_queue : short request queue between front and back
// Two-entry register queue; head is read combinationally.
// ----------------------------------------------------------------------------
module drl_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  drl_pkg::run_cmd_t               push_data,
    input  logic                            pop,
    output drl_pkg::run_cmd_t               head,
    output logic                            q_valid,
    output logic                            q_full,
    output logic [drl_pkg::QCNT_W-1:0]      count
);

    drl_pkg::run_cmd_t                  entry_reg [drl_pkg::QUEUE_DEPTH];
    logic [drl_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [drl_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [drl_pkg::QCNT_W-1:0]         count_reg, count_next;
    logic                               do_push, do_pop;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == drl_pkg::QCNT_W'(drl_pkg::QUEUE_DEPTH);
    assign count   = count_reg;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/drl_back.sv =====
// ----------------------------------------------------------------------------
// drl_back : running-cluster adder and output register
// Pops one request, adds its offset to the running cluster, holds the result.
// ----------------------------------------------------------------------------
module drl_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drl_pkg::run_cmd_t               head,
    input  logic                            q_valid,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [drl_pkg::WORD_W-1:0]      run_length,
    output logic signed [drl_pkg::WORD_W-1:0] cluster,
    output logic                            first_run
);

    logic [drl_pkg::WORD_W-1:0]  running_reg, running_next;
    logic [drl_pkg::WORD_W-1:0]  base, sum;
    logic                        valid_reg, valid_next;
    drl_pkg::status_t            status_reg;
    logic [drl_pkg::WORD_W-1:0]  length_reg, cluster_reg;
    logic                        first_reg;

    assign pop          = q_valid && (!valid_reg || !out_stall);
    assign base         = head.restart ? '0 : running_reg;
    assign sum          = base + head.offset;
    assign running_next = pop ? sum : running_reg;
    assign valid_next   = pop || (valid_reg && out_stall);

    assign out_valid  = valid_reg;
    assign status     = status_reg;
    assign run_length = length_reg;
    assign cluster    = cluster_reg;
    assign first_run  = first_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= head.status;
            length_reg  <= head.length;
            cluster_reg <= sum;
            first_reg   <= head.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            running_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            running_reg <= running_next;
        end
    end

endmodule
